@@ hw/rtl/lcddw_pkg.sv @@
// Shared types, constants and helper functions for the decimal number writer.
// Used by the front converter, the queue, the byte sequencer and the top level.
package lcddw_pkg;

    localparam int LINE_WIDTH = 16;
    localparam int ROW_OFFSET = 64;

    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int VALUE_W    = 32;
    localparam int COL_W      = 5;
    localparam int ROW_W      = 2;
    localparam int ND_W       = 4;
    localparam int CNT_W      = 5;
    localparam int COL_SUM_W  = 6;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;

    // One converted number waiting for the byte sequencer.
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [ND_W-1:0]  nd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ADDR,
        BK_DIGIT
    } back_state_t;

    // Set-address command for a column on row 0 or row 1.
    function automatic logic [7:0] addr_cmd(input logic [COL_W-1:0] col, input logic row1);
        logic [7:0] offs;
        begin
            offs = row1 ? 8'(ROW_OFFSET) : 8'd0;
            return CMD_SET_ADDR | (8'(col) + offs);
        end
    endfunction

endpackage

@@ hw/rtl/lcd_decimal_number_writer.sv @@
// Top level of the decimal number writer for a 16x2 character display.
// Depends on lcddw_pkg, lcddw_front, lcddw_fifo and lcddw_back.
//
// Each input transfer carries a 32-bit unsigned value and a starting cursor column and row.
// The block answers with one output transfer per byte: an optional set-address command
// (only when column <= 16 and row <= 1), then the decimal digits in ASCII, most significant
// first, with no leading zeros (zero prints '0'). When the column plus the digits already
// written passes 15, a set-address command for column 0 of the other row precedes the next
// digit. tuser flags data bytes, tlast marks the final digit. The front end converts the value
// with a shift-and-add-3 loop and then queues it; the sequencer fetches the job and sends one
// byte per cycle (up to 12) while m_tready is high, while the front end already converts the
// next number. With m_tready high, sustained throughput is thus set by the conversion loop.
module lcd_decimal_number_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [36:32] column, [38:37] row, [39] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast    // last byte for this number
);
    import lcddw_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    lcddw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[31:0]),
        .in_column (s_tdata[36:32]),
        .in_row    (s_tdata[38:37]),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    lcddw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    lcddw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (pop_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_is_data (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

@@ hw/rtl/lcddw_front.sv @@
// Front end: accepts a number and converts it to ten BCD digits by shift-and-add-3.
// Depends on lcddw_pkg; hands finished jobs to the queue.
module lcddw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          in_value,
    input  logic [4:0]           in_column,
    input  logic [1:0]           in_row,
    output logic                 push,
    output lcddw_pkg::job_t      push_job,
    input  logic                 q_full
);
    import lcddw_pkg::*;

    front_state_t        state_reg, state_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [ND_W-1:0]     nd;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Digit count is the position of the highest nonzero digit, at least one.
    always_comb
    begin
        nd = ND_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                nd = ND_W'(i + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        col_reg <= col_next;
        row_reg <= row_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        push_job   = '{bcd: bcd_reg, nd: nd, col: col_reg, row: row_reg};
        case (state_reg)
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    bin_next   = in_value;
                    bcd_next   = '0;
                    col_next   = in_column;
                    row_next   = in_row;
                    cnt_next   = '0;
                    state_next = FR_CONV;
                end
            end
            FR_CONV:
            begin
                {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                    state_next = FR_PUSH;
            end
            FR_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/lcddw_fifo.sv @@
// Two-entry queue of converted jobs between the front end and the sequencer.
// Depends on lcddw_pkg for the job type.
module lcddw_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcddw_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output lcddw_pkg::job_t pop_job,
    output logic            empty
);
    import lcddw_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ (push && !full);
        rptr_next  = rptr_reg ^ (pop && !empty);
        count_next = count_reg + 2'(push && !full) - 2'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wptr_reg] <= push_job;
    end

endmodule

@@ hw/rtl/lcddw_back.sv @@
// Byte sequencer: turns one queued job into address commands and ASCII digits.
// Depends on lcddw_pkg; drives the registered output stage.
module lcddw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  lcddw_pkg::job_t q_job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_is_data,
    output logic            out_last
);
    import lcddw_pkg::*;

    back_state_t          state_reg, state_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [ND_W-1:0]      nd_reg, nd_next;
    logic [ND_W-1:0]      k_reg, k_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 wrapped_reg, wrapped_next;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           obyte_reg, obyte_next;
    logic                 odata_reg, odata_next;
    logic                 olast_reg, olast_next;
    logic                 slot_free;
    logic [COL_SUM_W-1:0] col_sum;
    logic [ND_W-1:0]      dig_idx;
    logic [3:0]           digit;

    assign slot_free   = !ovalid_reg || out_ready;
    assign col_sum     = COL_SUM_W'(col_reg) + COL_SUM_W'(k_reg);
    assign dig_idx     = nd_reg - ND_W'(1) - k_reg;
    assign digit       = bcd_reg[4*dig_idx +: 4];
    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign out_is_data = odata_reg;
    assign out_last    = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
            k_reg      <= '0;
            nd_reg     <= ND_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            k_reg      <= k_next;
            nd_reg     <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg     <= bcd_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        wrapped_reg <= wrapped_next;
        obyte_reg   <= obyte_next;
        odata_reg   <= odata_next;
        olast_reg   <= olast_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        bcd_next     = bcd_reg;
        nd_next      = nd_reg;
        k_next       = k_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        wrapped_next = wrapped_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        obyte_next   = obyte_reg;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        pop          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop          = 1'b1;
                    bcd_next     = q_job.bcd;
                    nd_next      = q_job.nd;
                    col_next     = q_job.col;
                    row_next     = q_job.row;
                    k_next       = '0;
                    wrapped_next = 1'b0;
                    // Rows 2 and 3, or a column above 16, start without an address.
                    if (q_job.col <= COL_W'(LINE_WIDTH) && !q_job.row[1])
                        state_next = BK_ADDR;
                    else
                        state_next = BK_DIGIT;
                end
            end
            BK_ADDR:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = addr_cmd(col_reg, row_reg[0]);
                    odata_next  = 1'b0;
                    olast_next  = 1'b0;
                    state_next  = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    if (!wrapped_reg && col_sum > COL_SUM_W'(LINE_WIDTH - 1))
                    begin
                        // Wrap to column 0 of the other row before this digit.
                        wrapped_next = 1'b1;
                        row_next     = {1'b0, !row_reg[0]};
                        obyte_next   = addr_cmd('0, !row_reg[0]);
                        odata_next   = 1'b0;
                        olast_next   = 1'b0;
                    end
                    else
                    begin
                        obyte_next = ASCII_ZERO | {4'd0, digit};
                        odata_next = 1'b1;
                        if (k_reg == nd_reg - ND_W'(1))
                        begin
                            olast_next = 1'b1;
                            k_next     = '0;
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            olast_next = 1'b0;
                            k_next     = k_reg + ND_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    a_digit_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && odata_reg) |-> (obyte_reg >= ASCII_ZERO && obyte_reg <= ASCII_NINE))
        else $error("digit byte outside ASCII 0..9");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && olast_reg) |-> odata_reg)
        else $error("last marker on a command byte");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIGIT) |-> (k_reg < nd_reg))
        else $error("digit index past digit count");

    a_cmd_msb: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !odata_reg) |-> obyte_reg[7])
        else $error("command byte without set-address bit");

endmodule
